[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error(msg);

`endif

[design/tasa_pkg.sv]
// Constants, codes and control/status types for the tile atlas slot allocator.
package tasa_pkg;
	localparam int ATLAS_SIZE  = 2048;
	localparam int MIN_TILE    = 64;
	localparam int MAX_ATLASES = 8;
	localparam int GRID_CAP    = 32;
	localparam int SLOT_CAP    = 1024;

	localparam int DIM_W   = 13;
	localparam int PIX_W   = 11;
	localparam int PG_W    = 3;
	localparam int OPEN_W  = 4;
	localparam int SLOT_W  = 10;
	localparam int CNT_W   = 11;
	localparam int GRID_W  = 6;
	localparam int COORD_W = 5;
	localparam int STAT_W  = 3;
	localparam int STEP_W  = 4;
	localparam int MEM_AW  = PG_W + SLOT_W;

	localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOT_SQUARE = 3'd1;
	localparam logic [STAT_W-1:0] ST_RANGE      = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL       = 3'd3;
	localparam logic [STAT_W-1:0] ST_BAD_FREE   = 3'd4;

	typedef struct packed {
		logic              load;
		logic              scan_step;
		logic              use_found;
		logic              open_page;
		logic              grid_step;
		logic              page_write;
		logic              alloc;
		logic              take_mem;
		logic              div_step;
		logic              mul_x;
		logic              mul_y;
		logic              free_do;
		logic              set_err;
		logic [STAT_W-1:0] err_code;
		logic              emit;
	} tasa_cmd_t;

	typedef struct packed {
		logic              is_free;
		logic              bad_sq;
		logic              bad_rng;
		logic              open_zero;
		logic              scan_last;
		logic              found;
		logic              table_full;
		logic              step_last;
		logic              fresh_avail;
		logic              free_ok;
		logic              out_free;
		logic [OPEN_W-1:0] open_cnt;
	} tasa_stat_t;
endpackage

[design/tile_atlas_slot_allocator.sv]
// Top level of the tile atlas slot allocator.
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | action, tile size, free_atlas, free_tile
//  out     | output    | out_valid/out_stall | status, new_atlas, atlas/tile slot, col/row, bounds
// One item at a time. A free, a push that fails its checks and a push into a full
// table skip the arithmetic; a push into an open page runs the slot/grid divide,
// with an extra read when the slot comes from the freed list, and one that opens
// a page runs the grid search first. Every open page is scanned. The divide takes
// ten steps and the grid search six.
// Reset clears the page count, the sequencer and the result valid; the result
// register holds while out_valid and out_stall are both high.
`include "assert_macros.svh"
module tile_atlas_slot_allocator import tasa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [DIM_W-1:0]   tile_width,
	input  logic [DIM_W-1:0]   tile_height,
	input  logic [PG_W-1:0]    free_atlas,
	input  logic [SLOT_W-1:0]  free_tile,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic               new_atlas,
	output logic [PG_W-1:0]    atlas_slot,
	output logic [SLOT_W-1:0]  tile_slot,
	output logic [COORD_W-1:0] tile_col,
	output logic [COORD_W-1:0] tile_row,
	output logic [PIX_W-1:0]   start_x,
	output logic [PIX_W-1:0]   start_y,
	output logic [PIX_W-1:0]   end_x,
	output logic [PIX_W-1:0]   end_y
);
	tasa_cmd_t  cmd;
	tasa_stat_t stat;

	tasa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tasa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (action),
		.tile_width  (tile_width),
		.tile_height (tile_height),
		.free_atlas  (free_atlas),
		.free_tile   (free_tile),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.new_atlas   (new_atlas),
		.atlas_slot  (atlas_slot),
		.tile_slot   (tile_slot),
		.tile_col    (tile_col),
		.tile_row    (tile_row),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y)
	);

	`ASSERT_IMP(a_open_max, clk, arst_n, 1'b1, stat.open_cnt <= OPEN_W'(MAX_ATLASES), "page count overflow")
	`ASSERT_IMP(a_err_no_new, clk, arst_n, out_valid && (status != ST_OK), !new_atlas, "error result flags a new page")
	`ASSERT_NXT(a_busy_after_xfer, clk, arst_n, in_valid && !in_stall, in_stall, "second transfer taken while busy")
	`ASSERT_NXT(a_open_on_new, clk, arst_n, cmd.open_page, stat.open_cnt == $past(stat.open_cnt) + OPEN_W'(1), "page open lost")
endmodule

[design/tasa_ctrl.sv]
// Sequencer for push and free transfers.
module tasa_ctrl import tasa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  tasa_stat_t stat,
	output tasa_cmd_t  cmd
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_GRID   = 4'd4;
	localparam logic [3:0] S_PGWR   = 4'd5;
	localparam logic [3:0] S_ALLOC  = 4'd6;
	localparam logic [3:0] S_MEMW   = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_MULX   = 4'd9;
	localparam logic [3:0] S_MULY   = 4'd10;
	localparam logic [3:0] S_FREE   = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;

	logic [3:0] state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.is_free) begin
					state_d = S_FREE;
				end else if (stat.bad_sq) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_NOT_SQUARE;
					state_d      = S_DONE;
				end else if (stat.bad_rng) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_RANGE;
					state_d      = S_DONE;
				end else if (stat.open_zero) begin
					state_d = S_DECIDE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.found) begin
					cmd.use_found = 1'b1;
					state_d       = S_ALLOC;
				end else if (stat.table_full) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_FULL;
					state_d      = S_DONE;
				end else begin
					cmd.open_page = 1'b1;
					state_d       = S_GRID;
				end
			end
			S_GRID: begin
				cmd.grid_step = 1'b1;
				if (stat.step_last) state_d = S_PGWR;
			end
			S_PGWR: begin
				cmd.page_write = 1'b1;
				state_d        = S_ALLOC;
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d   = stat.fresh_avail ? S_DIV : S_MEMW;
			end
			S_MEMW: begin
				cmd.take_mem = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.step_last) state_d = S_MULX;
			end
			S_MULX: begin
				cmd.mul_x = 1'b1;
				state_d   = S_MULY;
			end
			S_MULY: begin
				cmd.mul_y = 1'b1;
				state_d   = S_DONE;
			end
			S_FREE: begin
				if (stat.free_ok) begin
					cmd.free_do = 1'b1;
				end else begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_BAD_FREE;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end
endmodule

[design/tasa_dp.sv]
// Page tables, freed-slot memory, grid/slot arithmetic and the output register.
module tasa_dp import tasa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tasa_cmd_t          cmd,
	output tasa_stat_t         stat,
	input  logic               action,
	input  logic [DIM_W-1:0]   tile_width,
	input  logic [DIM_W-1:0]   tile_height,
	input  logic [PG_W-1:0]    free_atlas,
	input  logic [SLOT_W-1:0]  free_tile,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic               new_atlas,
	output logic [PG_W-1:0]    atlas_slot,
	output logic [SLOT_W-1:0]  tile_slot,
	output logic [COORD_W-1:0] tile_col,
	output logic [COORD_W-1:0] tile_row,
	output logic [PIX_W-1:0]   start_x,
	output logic [PIX_W-1:0]   start_y,
	output logic [PIX_W-1:0]   end_x,
	output logic [PIX_W-1:0]   end_y
);
	localparam int GPROD_W = GRID_W + DIM_W;
	localparam int MPROD_W = COORD_W + DIM_W;

	// per-page tables, one entry per atlas
	logic [DIM_W-1:0]  pg_size_q  [MAX_ATLASES];
	logic [GRID_W-1:0] pg_grid_q  [MAX_ATLASES];
	logic [CNT_W-1:0]  pg_n_q     [MAX_ATLASES];
	logic [CNT_W-1:0]  pg_fresh_q [MAX_ATLASES];
	logic [SLOT_W-1:0] pg_head_q  [MAX_ATLASES];
	logic [SLOT_W-1:0] pg_tail_q  [MAX_ATLASES];
	logic [CNT_W-1:0]  pg_fill_q  [MAX_ATLASES];

	logic [SLOT_W-1:0] freed_mem [MAX_ATLASES*SLOT_CAP];
	logic [SLOT_W-1:0] rd_q;

	logic              action_q;
	logic [DIM_W-1:0]  width_q, height_q;
	logic [SLOT_W-1:0] ftile_q;
	logic [OPEN_W-1:0] open_q;
	logic [PG_W-1:0]   idx_q, page_q;
	logic              found_q;
	logic [STEP_W-1:0] step_q;
	logic [GRID_W-1:0] g_q;
	logic [SLOT_W-1:0] dq_q;
	logic [COORD_W-1:0] rem_q;

	logic [STAT_W-1:0]  res_status_q;
	logic               res_new_q;
	logic [PG_W-1:0]    res_atlas_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic [COORD_W-1:0] res_col_q, res_row_q;
	logic [PIX_W-1:0]   res_sx_q, res_sy_q, res_ex_q, res_ey_q;
	logic               out_valid_q;

	// current page view
	logic [DIM_W-1:0]  cur_size;
	logic [GRID_W-1:0] cur_grid;
	logic [CNT_W-1:0]  cur_n, cur_fresh, cur_fill;
	logic [SLOT_W-1:0] cur_head, cur_tail;
	logic              cur_match;

	assign cur_size  = pg_size_q[idx_q];
	assign cur_grid  = pg_grid_q[idx_q];
	assign cur_n     = pg_n_q[idx_q];
	assign cur_fresh = pg_fresh_q[idx_q];
	assign cur_fill  = pg_fill_q[idx_q];
	assign cur_head  = pg_head_q[idx_q];
	assign cur_tail  = pg_tail_q[idx_q];
	assign cur_match = (cur_size == width_q) &&
		((cur_fresh < cur_n) || (cur_fill != '0));

	// grid search: largest g with g*size <= ATLAS_SIZE, one bit a step
	logic [GRID_W-1:0]  g_trial;
	logic [GPROD_W-1:0] g_prod;
	logic [GRID_W-1:0]  g_cap;
	assign g_trial = g_q | GRID_W'(1 << step_q);
	assign g_prod  = GPROD_W'(g_trial) * GPROD_W'(width_q);
	assign g_cap   = (g_q > GRID_W'(GRID_CAP)) ? GRID_W'(GRID_CAP) : g_q;

	// restoring divide of slot by grid, one quotient bit a step
	logic [GRID_W-1:0] div_t;
	assign div_t = {rem_q, dq_q[SLOT_W-1]};

	// shared coordinate multiplier
	logic [COORD_W-1:0] mul_a;
	logic [MPROD_W-1:0] mul_p, mul_e;
	assign mul_a = cmd.mul_x ? rem_q : dq_q[COORD_W-1:0];
	assign mul_p = MPROD_W'(mul_a) * MPROD_W'(width_q);
	assign mul_e = mul_p + MPROD_W'(width_q) - MPROD_W'(1);

	logic [MEM_AW-1:0] rd_addr, wr_addr;
	assign rd_addr = {idx_q, cur_head};
	assign wr_addr = {idx_q, cur_tail};

	always_comb begin
		stat.is_free     = action_q;
		stat.bad_sq      = (width_q != height_q);
		stat.bad_rng     = (width_q < DIM_W'(MIN_TILE)) || (width_q > DIM_W'(ATLAS_SIZE));
		stat.open_zero   = (open_q == '0);
		stat.scan_last   = (OPEN_W'(idx_q) + OPEN_W'(1) == open_q);
		stat.found       = found_q;
		stat.table_full  = (open_q >= OPEN_W'(MAX_ATLASES));
		stat.step_last   = (step_q == '0);
		stat.fresh_avail = (cur_fresh < cur_n);
		stat.free_ok     = (OPEN_W'(idx_q) < open_q) && (CNT_W'(ftile_q) < cur_n) &&
			(cur_fill < CNT_W'(SLOT_CAP));
		stat.out_free    = !out_valid_q || !out_stall;
		stat.open_cnt    = open_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.open_page) open_q <= open_q + OPEN_W'(1);
			if (cmd.emit)              out_valid_q <= 1'b1;
			else if (!out_stall)       out_valid_q <= 1'b0;
		end
	end

	// freed-slot memory
	always_ff @(posedge clk) begin
		if (cmd.free_do) freed_mem[wr_addr] <= ftile_q;
		rd_q <= freed_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q     <= action;
			width_q      <= tile_width;
			height_q     <= tile_height;
			ftile_q      <= free_tile;
			idx_q        <= action ? free_atlas : '0;
			found_q      <= 1'b0;
			res_status_q <= ST_OK;
			res_new_q    <= 1'b0;
			res_atlas_q  <= '0;
			res_slot_q   <= '0;
			res_col_q    <= '0;
			res_row_q    <= '0;
			res_sx_q     <= '0;
			res_sy_q     <= '0;
			res_ex_q     <= '0;
			res_ey_q     <= '0;
		end
		if (cmd.set_err) res_status_q <= cmd.err_code;
		if (cmd.scan_step) begin
			if (cur_match) begin
				found_q <= 1'b1;
				page_q  <= idx_q;
			end
			idx_q <= idx_q + PG_W'(1);
		end
		if (cmd.use_found) idx_q <= page_q;
		if (cmd.open_page) begin
			idx_q     <= open_q[PG_W-1:0];
			res_new_q <= 1'b1;
			g_q       <= '0;
			step_q    <= STEP_W'(GRID_W - 1);
		end
		if (cmd.grid_step) begin
			if (g_prod <= GPROD_W'(ATLAS_SIZE)) g_q <= g_trial;
			step_q <= step_q - STEP_W'(1);
		end
		if (cmd.page_write) begin
			pg_size_q[idx_q]  <= width_q;
			pg_grid_q[idx_q]  <= g_cap;
			pg_n_q[idx_q]     <= CNT_W'(g_cap * g_cap);
			pg_fresh_q[idx_q] <= '0;
			pg_head_q[idx_q]  <= '0;
			pg_tail_q[idx_q]  <= '0;
			pg_fill_q[idx_q]  <= '0;
		end
		if (cmd.alloc) begin
			res_atlas_q <= idx_q;
			rem_q       <= '0;
			step_q      <= STEP_W'(SLOT_W - 1);
			if (cur_fresh < cur_n) begin
				dq_q              <= cur_fresh[SLOT_W-1:0];
				res_slot_q        <= cur_fresh[SLOT_W-1:0];
				pg_fresh_q[idx_q] <= cur_fresh + CNT_W'(1);
			end else begin
				pg_head_q[idx_q] <= cur_head + SLOT_W'(1);
				pg_fill_q[idx_q] <= cur_fill - CNT_W'(1);
			end
		end
		if (cmd.take_mem) begin
			dq_q       <= rd_q;
			res_slot_q <= rd_q;
		end
		if (cmd.div_step) begin
			if (div_t >= cur_grid) begin
				rem_q <= COORD_W'(div_t - cur_grid);
				dq_q  <= {dq_q[SLOT_W-2:0], 1'b1};
			end else begin
				rem_q <= div_t[COORD_W-1:0];
				dq_q  <= {dq_q[SLOT_W-2:0], 1'b0};
			end
			step_q <= step_q - STEP_W'(1);
		end
		if (cmd.mul_x) begin
			res_col_q <= rem_q;
			res_sx_q  <= mul_p[PIX_W-1:0];
			res_ex_q  <= mul_e[PIX_W-1:0];
		end
		if (cmd.mul_y) begin
			res_row_q <= dq_q[COORD_W-1:0];
			res_sy_q  <= mul_p[PIX_W-1:0];
			res_ey_q  <= mul_e[PIX_W-1:0];
		end
		if (cmd.free_do) begin
			pg_tail_q[idx_q] <= cur_tail + SLOT_W'(1);
			pg_fill_q[idx_q] <= cur_fill + CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status     <= res_status_q;
			new_atlas  <= res_new_q;
			atlas_slot <= res_atlas_q;
			tile_slot  <= res_slot_q;
			tile_col   <= res_col_q;
			tile_row   <= res_row_q;
			start_x    <= res_sx_q;
			start_y    <= res_sy_q;
			end_x      <= res_ex_q;
			end_y      <= res_ey_q;
		end
	end

	assign out_valid = out_valid_q;
endmodule

[tb/tile_atlas_slot_allocator_tb.sv]
// Testbench for the tile atlas slot allocator: directed table, random pushes and frees, then a freed-list overflow.
`timescale 1ns / 1ps
module tile_atlas_slot_allocator_tb;
	import tasa_pkg::*;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_FREE = 1'b1;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               new_atlas;
		logic [PG_W-1:0]    atlas_slot;
		logic [SLOT_W-1:0]  tile_slot;
		logic [COORD_W-1:0] tile_col;
		logic [COORD_W-1:0] tile_row;
		logic [PIX_W-1:0]   start_x;
		logic [PIX_W-1:0]   start_y;
		logic [PIX_W-1:0]   end_x;
		logic [PIX_W-1:0]   end_y;
	} placement_t;

	typedef struct packed {
		logic              action;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [PG_W-1:0]   fa;
		logic [SLOT_W-1:0] ft;
		logic              typed;
		logic [STAT_W-1:0] typed_status;
	} req_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [DIM_W-1:0] tile_width = '0;
	logic [DIM_W-1:0] tile_height = '0;
	logic [PG_W-1:0] free_atlas = '0;
	logic [SLOT_W-1:0] free_tile = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	wire placement_t got;

	always #2 clk = ~clk;

	tile_atlas_slot_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .tile_width(tile_width), .tile_height(tile_height),
		.free_atlas(free_atlas), .free_tile(free_tile),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(got.status), .new_atlas(got.new_atlas), .atlas_slot(got.atlas_slot),
		.tile_slot(got.tile_slot), .tile_col(got.tile_col), .tile_row(got.tile_row),
		.start_x(got.start_x), .start_y(got.start_y), .end_x(got.end_x), .end_y(got.end_y)
	);

	// allocator shadow
	int pages_open;
	int pg_size [MAX_ATLASES];
	int pg_grid [MAX_ATLASES];
	int pg_fresh [MAX_ATLASES];
	int pg_freed [MAX_ATLASES][$];

	placement_t pending_placements [$];
	int held_page [$];
	int held_slot [$];
	int errors = 0;
	int n_alloc = 0, n_freed = 0, n_rejected = 0, n_opened = 0;
	bit quiet = 1'b0;

	function automatic placement_t place_tile(logic act, int w, int h, int fa, int ft);
		placement_t r;
		int p, g, slot, col, row;
		bit found;
		r = '0;
		found = 1'b0;
		p = 0;
		if (act == ACT_FREE) begin
			if (fa >= pages_open || ft >= pg_grid[fa] * pg_grid[fa]
					|| pg_freed[fa].size() >= SLOT_CAP) begin
				r.status = ST_BAD_FREE;
			end else begin
				pg_freed[fa].push_back(ft);
				n_freed++;
			end
			return r;
		end
		if (w != h) begin
			r.status = ST_NOT_SQUARE;
			return r;
		end
		if (w < MIN_TILE || w > ATLAS_SIZE) begin
			r.status = ST_RANGE;
			return r;
		end
		for (int i = 0; i < pages_open; i++)
			if (pg_size[i] == w && (pg_fresh[i] < pg_grid[i] * pg_grid[i]
					|| pg_freed[i].size() != 0)) begin
				p = i;
				found = 1'b1;
			end
		if (!found) begin
			if (pages_open >= MAX_ATLASES) begin
				r.status = ST_FULL;
				return r;
			end
			p = pages_open++;
			g = ATLAS_SIZE / w;
			pg_size[p] = w;
			pg_grid[p] = (g > GRID_CAP) ? GRID_CAP : g;
			pg_fresh[p] = 0;
			pg_freed[p].delete();
			r.new_atlas = 1'b1;
			n_opened++;
		end
		g = pg_grid[p];
		if (pg_fresh[p] < g * g) slot = pg_fresh[p]++;
		else slot = pg_freed[p].pop_front();
		col = slot % g;
		row = slot / g;
		r.status = ST_OK;
		r.atlas_slot = PG_W'(p);
		r.tile_slot = SLOT_W'(slot);
		r.tile_col = COORD_W'(col);
		r.tile_row = COORD_W'(row);
		r.start_x = PIX_W'(col * w);
		r.start_y = PIX_W'(row * w);
		r.end_x = PIX_W'((col + 1) * w - 1);
		r.end_y = PIX_W'((row + 1) * w - 1);
		held_page.push_back(p);
		held_slot.push_back(slot);
		n_alloc++;
		return r;
	endfunction

	task automatic send(req_row_t rq);
		placement_t r;
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= rq.action;
		tile_width <= rq.w;
		tile_height <= rq.h;
		free_atlas <= rq.fa;
		free_tile <= rq.ft;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		r = place_tile(rq.action, int'(rq.w), int'(rq.h), int'(rq.fa), int'(rq.ft));
		if (r.status != ST_OK) n_rejected++;
		if (rq.typed) begin
			r = '0;
			r.status = rq.typed_status;
		end
		pending_placements.push_back(r);
	endtask

	// receiver stall bursts
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		placement_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_placements.size() == 0) begin
				$display("%0t: unexpected transfer, actual %p", $time, got);
				errors++;
			end else begin
				e = pending_placements.pop_front();
				if (got !== e) begin
					$display("%0t: mismatch, expected %p", $time, e);
					$display("%0t:           actual   %p", $time, got);
					errors++;
				end
			end
		end
	end

	function automatic req_row_t mk(logic act, int w, int h, int fa, int ft,
			logic typed = 1'b0, logic [STAT_W-1:0] st = ST_OK);
		req_row_t rq;
		rq.action = act;
		rq.w = DIM_W'(w);
		rq.h = DIM_W'(h);
		rq.fa = PG_W'(fa);
		rq.ft = SLOT_W'(ft);
		rq.typed = typed;
		rq.typed_status = st;
		return rq;
	endfunction

	req_row_t directed [$];
	int sizes [7] = '{2048, 64, 1024, 1000, 65, 2047, 512};

	function automatic req_row_t random_req();
		int k, s, j;
		k = $urandom_range(0, 99);
		if (k < 45) begin
			s = sizes[$urandom_range(0, 6)];
			return mk(ACT_PUSH, s, s, 0, 0);
		end else if (k < 80 && held_page.size() != 0) begin
			j = $urandom_range(0, held_page.size() - 1);
			k = held_page[j];
			s = held_slot[j];
			// mostly release, sometimes keep it around for a double free
			if ($urandom_range(0, 4) != 0) begin
				held_page.delete(j);
				held_slot.delete(j);
			end
			return mk(ACT_FREE, 0, 0, k, s);
		end else if (k < 90) begin
			return mk(ACT_FREE, $urandom_range(0, 8191), $urandom_range(0, 8191),
				$urandom_range(0, 7), $urandom_range(0, 1023));
		end else begin
			return mk(1'($urandom_range(0, 1)), $urandom_range(0, 8191),
				$urandom_range(0, 8191), $urandom_range(0, 7), $urandom_range(0, 1023));
		end
	endfunction

	initial begin
		directed.push_back(mk(ACT_FREE, 0, 0, 0, 0, 1'b1, ST_BAD_FREE));
		directed.push_back(mk(ACT_PUSH, 100, 99, 0, 0, 1'b1, ST_NOT_SQUARE));
		directed.push_back(mk(ACT_PUSH, 0, 0, 0, 0, 1'b1, ST_RANGE));
		directed.push_back(mk(ACT_PUSH, 63, 63, 0, 0, 1'b1, ST_RANGE));
		directed.push_back(mk(ACT_PUSH, 2049, 2049, 0, 0, 1'b1, ST_RANGE));
		directed.push_back(mk(ACT_PUSH, 8191, 8191, 7, 1023, 1'b1, ST_RANGE));
		directed.push_back(mk(ACT_PUSH, 2048, 2048, 0, 0));
		directed.push_back(mk(ACT_PUSH, 2048, 2048, 0, 0));
		directed.push_back(mk(ACT_FREE, 0, 0, 0, 0));
		directed.push_back(mk(ACT_PUSH, 2048, 2048, 0, 0));
		directed.push_back(mk(ACT_FREE, 0, 0, 7, 0, 1'b1, ST_BAD_FREE));
		directed.push_back(mk(ACT_FREE, 0, 0, 0, 1, 1'b1, ST_BAD_FREE));
		directed.push_back(mk(ACT_PUSH, 64, 64, 0, 0));
		directed.push_back(mk(ACT_PUSH, 1024, 1024, 0, 0));
		directed.push_back(mk(ACT_PUSH, 1000, 1000, 0, 0));
		directed.push_back(mk(ACT_PUSH, 65, 65, 0, 0));
		directed.push_back(mk(ACT_PUSH, 4096, 4096, 0, 0, 1'b1, ST_RANGE));
		directed.push_back(mk(ACT_PUSH, 2047, 2047, 0, 0));
		directed.push_back(mk(ACT_PUSH, 512, 512, 0, 0));
		directed.push_back(mk(ACT_PUSH, 128, 128, 0, 0, 1'b1, ST_FULL));
		directed.push_back(mk(ACT_FREE, 0, 0, 2, 1023));
		directed.push_back(mk(ACT_FREE, 0, 0, 4, 4, 1'b1, ST_BAD_FREE));
		directed.push_back(mk(ACT_PUSH, 64, 64, 5, 5));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send(directed[i]);
		for (int n = 0; n < 80; n++) send(random_req());
		// fill the freed list of the small-tile page past its depth
		for (int n = 0; n < 1030; n++) begin
			if (n == 980) quiet = 1'b1;
			send(mk(ACT_FREE, 0, 0, 2, $urandom_range(0, 1023)));
		end
		for (int n = 0; n < 20; n++) send(mk(ACT_PUSH, 64, 64, 0, 0));
		in_valid <= 1'b0;

		while (pending_placements.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d allocations (%0d pages opened), %0d frees, %0d rejects",
			n_alloc, n_opened, n_freed, n_rejected);
		$display("including a freed-list overflow on the 64-pixel page");
		if (errors == 0)
			$display("tile_atlas_slot_allocator_tb: done, clean");
		else
			$display("tile_atlas_slot_allocator_tb: done, errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("tile_atlas_slot_allocator_tb: done, errors");
		$finish;
	end
endmodule
